>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, muted while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, for a check that is only meaningful when the output holds a transaction.
`define ASSERT_OUT(label, clk, rst_n, vld, prop, msg) \
    `ASSERT_CLK(label, clk, rst_n, (vld) |-> (prop), msg)

// A stalled transaction stays offered with its payload unchanged.
`define ASSERT_HOLD(label, clk, rst_n, vld, rdy, data, msg) \
    `ASSERT_CLK(label, clk, rst_n, (vld) && !(rdy) |=> (vld) && $stable(data), msg)

`endif

>>> rtl/spv_pkg.sv
`default_nettype none

package spv_pkg;

    // Field widths
    localparam int CNT_W  = 9;
    localparam int SUM_W  = 17;
    localparam int WAIT_W = 20;

    localparam int BUFFER_BYTES_DEF = 256;
    localparam logic [WAIT_W-1:0] TIMEOUT_RESET = WAIT_W'(25000);
    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    // Length limits
    localparam logic [CNT_W-1:0] LEN_MIN   = CNT_W'(6);
    localparam logic [CNT_W-1:0] LEN_EIGHT = CNT_W'(8);

    // Request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Command codes refused on short packets
    localparam logic [7:0] CODE_0A = 8'h0A;
    localparam logic [7:0] CODE_E0 = 8'hE0;
    localparam logic [7:0] CODE_E4 = 8'hE4;
    localparam logic [7:0] CODE_E6 = 8'hE6;
    localparam logic [7:0] CODE_E8 = 8'hE8;

    typedef enum logic [2:0] {
        ST_WAIT     = 3'd0,
        ST_OK       = 3'd1,
        ST_SUM_BAD  = 3'd2,
        ST_REJECT   = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_OVERFLOW = 3'd5
    } spv_status_t;

    // Packet accumulation state
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum;
        logic [7:0]        addr;
        logic [7:0]        code;
        logic [7:0]        prev;
        logic [7:0]        last;
        logic [WAIT_W-1:0] wait_cnt;
    } spv_state_t;

    // One result transaction
    typedef struct packed {
        spv_status_t      status;
        logic [CNT_W-1:0] len;
        logic [7:0]       addr;
        logic [7:0]       code;
    } spv_result_t;

endpackage

`default_nettype wire

>>> rtl/spv_step.sv
`default_nettype none

// Next-state and result logic for one received byte or idle tick.
module spv_step
    import spv_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic              req_type,
    input  logic [7:0]        byte_value,
    input  logic [WAIT_W-1:0] timeout_limit,
    input  spv_state_t        cur,
    output spv_state_t        nxt,
    output spv_result_t       res
);

    logic [WAIT_W-1:0] wait_inc;
    logic [CNT_W-1:0]  b_cnt;
    logic [SUM_W-1:0]  b_sum;
    logic [7:0]        b_addr;
    logic [7:0]        b_code;
    logic [SUM_W-1:0]  calc;
    logic [SUM_W-1:0]  trailer;
    logic              reject6;
    logic              reject8;
    logic              rejected;

    // Saturating wait counter increment
    assign wait_inc = (cur.wait_cnt == WAIT_MAX) ? cur.wait_cnt : cur.wait_cnt + 1'b1;

    // Packet contents once this byte is appended
    assign b_cnt  = cur.count + 1'b1;
    assign b_sum  = (cur.count != '0) ? cur.sum + SUM_W'(byte_value) : cur.sum;
    assign b_addr = (cur.count == CNT_W'(1)) ? byte_value : cur.addr;
    assign b_code = (cur.count == CNT_W'(2)) ? byte_value : cur.code;

    // Checksum over bytes 1..n-3 against the big-endian trailer
    assign calc    = b_sum - SUM_W'(cur.last) - SUM_W'(byte_value);
    assign trailer = {1'b0, cur.last, byte_value};

    // Code filters for short packets
    always_comb
    begin
        case (b_code) inside
            CODE_0A, CODE_E0, CODE_E4, CODE_E6, CODE_E8: reject6 = 1'b1;
            default:                                     reject6 = 1'b0;
        endcase
        case (b_code) inside
            CODE_E0, CODE_E4: reject8 = 1'b1;
            default:          reject8 = 1'b0;
        endcase
    end

    assign rejected = ((b_cnt == LEN_MIN) && reject6) || ((b_cnt == LEN_EIGHT) && reject8);

    // Transaction decision
    always_comb
    begin
        nxt        = cur;
        res.status = ST_WAIT;
        res.len    = cur.count;
        res.addr   = cur.addr;
        res.code   = cur.code;

        if (cur.wait_cnt > timeout_limit)
        begin
            // stale partial packet: drop it, any byte here is lost
            nxt        = '0;
            res.status = ST_TIMEOUT;
        end
        else if ((req_type == REQ_TICK) || (cur.count >= CNT_W'(BUFFER_BYTES)))
        begin
            if (cur.wait_cnt != '0)
            begin
                nxt.wait_cnt = wait_inc;
            end
            res.status = (req_type == REQ_TICK) ? ST_WAIT : ST_OVERFLOW;
        end
        else
        begin
            nxt.count = b_cnt;
            nxt.sum   = b_sum;
            nxt.addr  = b_addr;
            nxt.code  = b_code;
            nxt.prev  = cur.last;
            nxt.last  = byte_value;
            res.len   = b_cnt;
            res.addr  = b_addr;
            res.code  = b_code;

            if ((b_cnt < LEN_MIN) || b_cnt[0])
            begin
                nxt.wait_cnt = wait_inc;
                res.status   = ST_WAIT;
            end
            else if (rejected)
            begin
                nxt.wait_cnt = wait_inc;
                res.status   = ST_REJECT;
            end
            else if (calc != trailer)
            begin
                nxt.wait_cnt = wait_inc;
                res.status   = ST_SUM_BAD;
            end
            else
            begin
                // good packet is reported once, then the buffer starts over
                nxt        = '0;
                res.status = ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/serial_packet_receive_validator_core.sv
// An accepted input transaction waits in the input register, then moves to the result register and is offered.
// Throughput: one byte or idle tick per cycle while the result side does not stall; the packet state (count, sum,
// trailer bytes, wait counter) is updated together with the result register.
// Reset (rst_n low, asynchronous): packet state, wait counter and both valid
// flags clear; timeout_limit returns to 25000.
`default_nettype none

module serial_packet_receive_validator_core
    import spv_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WAIT_W-1:0] timeout_limit,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [7:0]        byte_value,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [CNT_W-1:0]  packet_length,
    output logic [7:0]        address_byte,
    output logic [7:0]        command_byte
);

    logic              in_valid_reg;
    logic              req_type_reg;
    logic [7:0]        byte_value_reg;
    logic [WAIT_W-1:0] limit_reg;
    spv_state_t        state_reg;
    spv_state_t        state_next;
    spv_result_t       result_next;
    spv_result_t       result_reg;
    logic              out_valid_reg;
    logic              advance;

    // Held item moves to the result register when that slot is free
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= timeout_limit;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg   <= req_type;
            byte_value_reg <= byte_value;
        end
    end

    // Packet checker
    spv_step #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_step (
        .req_type      (req_type_reg),
        .byte_value    (byte_value_reg),
        .timeout_limit (limit_reg),
        .cur           (state_reg),
        .nxt           (state_next),
        .res           (result_next)
    );

    // Packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign packet_length = result_reg.len;
    assign address_byte  = result_reg.addr;
    assign command_byte  = result_reg.code;

endmodule

`default_nettype wire

>>> rtl/spv_checker.sv
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the validator.
module spv_checker
    import spv_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [2:0]        status,
    input wire logic [CNT_W-1:0]  packet_length,
    input wire logic [7:0]        address_byte,
    input wire logic [7:0]        command_byte
);

    logic [27:0] out_payload;
    logic        ok_out;
    logic        reject_out;
    logic        len_ok;
    logic        len_6_or_8;

    assign out_payload = {status, packet_length, address_byte, command_byte};
    assign ok_out      = out_valid && (status == ST_OK);
    assign reject_out  = out_valid && (status == ST_REJECT);
    assign len_ok      = (packet_length >= LEN_MIN) && !packet_length[0];
    assign len_6_or_8  = (packet_length == LEN_MIN) || (packet_length == LEN_EIGHT);

    // A stalled result transaction keeps its payload
    `ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_payload, "result not held")

    // Only defined status codes leave the block
    `ASSERT_OUT(a_status, clk, rst_n, out_valid, status <= ST_OVERFLOW, "bad status code")

    // A good packet is even and at least six bytes
    `ASSERT_OUT(a_ok_len, clk, rst_n, ok_out, len_ok, "good packet with bad length")

    // Code rejection only happens at lengths six and eight
    `ASSERT_OUT(a_reject_len, clk, rst_n, reject_out, len_6_or_8, "code reject at wrong length")

endmodule

bind serial_packet_receive_validator_core spv_checker u_spv_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import spv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WAIT_W-1:0] timeout_limit = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              req_type = REQ_BYTE;
    logic [7:0]        byte_value = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        status;
    logic [CNT_W-1:0]  packet_length;
    logic [7:0]        address_byte;
    logic [7:0]        command_byte;

    // Predicted packet state and register copy
    logic [CNT_W-1:0]  pkt_count = '0;
    logic [SUM_W-1:0]  pkt_sum = '0;
    logic [7:0]        pkt_addr = '0;
    logic [7:0]        pkt_code = '0;
    logic [7:0]        pkt_prev = '0;
    logic [7:0]        pkt_last = '0;
    logic [WAIT_W-1:0] wait_ticks = '0;
    logic [WAIT_W-1:0] limit_reg = TIMEOUT_RESET;

    spv_result_t pending_results[$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int items_sent = 0;
    int fail_count = 0;
    int cycle_count = 0;

    serial_packet_receive_validator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .timeout_limit (timeout_limit),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .byte_value    (byte_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .packet_length (packet_length),
        .address_byte  (address_byte),
        .command_byte  (command_byte)
    );

    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** serial_packet_receive_validator_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Packet validator prediction
    // ---------------------------------------------------------------
    function automatic void forget_packet();
        pkt_count = '0;
        pkt_sum   = '0;
        pkt_addr  = '0;
        pkt_code  = '0;
        pkt_prev  = '0;
        pkt_last  = '0;
    endfunction

    // wait counter saturates
    function automatic void bump_wait();
        if (wait_ticks != WAIT_MAX)
            wait_ticks = wait_ticks + 1'b1;
    endfunction

    function automatic spv_status_t judge_packet();
        logic [SUM_W-1:0] calc;
        logic             short_reject;
        logic             eight_reject;
        short_reject = (pkt_code == CODE_0A) || (pkt_code == CODE_E0) ||
                       (pkt_code == CODE_E4) || (pkt_code == CODE_E6) ||
                       (pkt_code == CODE_E8);
        eight_reject = (pkt_code == CODE_E0) || (pkt_code == CODE_E4);
        if (pkt_count < LEN_MIN || pkt_count[0])
        begin
            bump_wait();
            return ST_WAIT;
        end
        if ((pkt_count == LEN_MIN && short_reject) ||
            (pkt_count == LEN_EIGHT && eight_reject))
        begin
            bump_wait();
            return ST_REJECT;
        end
        // sum of bytes 1..n-3 against big-endian trailer
        calc = pkt_sum - SUM_W'(pkt_prev) - SUM_W'(pkt_last);
        if (calc != SUM_W'({pkt_prev, pkt_last}))
        begin
            bump_wait();
            return ST_SUM_BAD;
        end
        return ST_OK;
    endfunction

    function automatic spv_result_t validate_step(input logic kind, input logic [7:0] data);
        spv_result_t r;
        if (wait_ticks > limit_reg)
        begin
            // stale partial packet: dropped, incoming byte discarded
            r.status = ST_TIMEOUT;
            r.len    = pkt_count;
            r.addr   = pkt_addr;
            r.code   = pkt_code;
            forget_packet();
            wait_ticks = '0;
        end
        else if (kind == REQ_TICK || pkt_count >= CNT_W'(BUFFER_BYTES_DEF))
        begin
            if (wait_ticks != '0)
                bump_wait();
            r.status = (kind == REQ_TICK) ? ST_WAIT : ST_OVERFLOW;
            r.len    = pkt_count;
            r.addr   = pkt_addr;
            r.code   = pkt_code;
        end
        else
        begin
            if (pkt_count >= 1)
                pkt_sum = pkt_sum + SUM_W'(data);
            if (pkt_count == 1)
                pkt_addr = data;
            if (pkt_count == 2)
                pkt_code = data;
            pkt_prev  = pkt_last;
            pkt_last  = data;
            pkt_count = pkt_count + 1'b1;
            r.status  = judge_packet();
            r.len     = pkt_count;
            r.addr    = pkt_addr;
            r.code    = pkt_code;
            if (r.status == ST_OK)
            begin
                forget_packet();
                wait_ticks = '0;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        spv_result_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result status=%0d len=%0d addr=%02h cmd=%02h",
                         $time, status, packet_length, address_byte, command_byte);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || packet_length !== want.len ||
                    address_byte !== want.addr || command_byte !== want.code)
                begin
                    fail_count++;
                    $display({"%0t: mismatch expected status=%0d len=%0d addr=%02h ",
                              "cmd=%02h, actual status=%0d len=%0d addr=%02h cmd=%02h"},
                             $time, want.status, want.len, want.addr, want.code,
                             status, packet_length, address_byte, command_byte);
                end
            end
        end
    end

    // Result side ready, with random stalls and requested hold-offs
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Driving tasks
    // ---------------------------------------------------------------
    task automatic offer_request(input logic kind, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        byte_value <= data;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(validate_step(kind, data));
        items_sent++;
    endtask

    task automatic pause_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        pause_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [WAIT_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid     <= 1'b1;
        timeout_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // builds a frame with a correct trailer, or a corrupted one when corrupt is set, and sends its first cut bytes
    task automatic send_frame(input int len, input logic [7:0] addr, input logic [7:0] code,
                              input bit corrupt, input int cut);
        logic [7:0]  frame_buf [BUFFER_BYTES_DEF];
        logic [15:0] csum;
        int          i;
        csum = '0;
        frame_buf[0] = 8'($urandom);
        frame_buf[1] = addr;
        frame_buf[2] = code;
        for (i = 3; i <= len - 3; i++)
            frame_buf[i] = 8'($urandom);
        for (i = 1; i <= len - 3; i++)
            csum = csum + 16'(frame_buf[i]);
        frame_buf[len-2] = csum[15:8];
        frame_buf[len-1] = csum[7:0] ^ (corrupt ? 8'($urandom_range(255, 1)) : 8'h00);
        for (i = 0; i < cut; i++)
            offer_request(REQ_BYTE, frame_buf[i]);
    endtask

    // idle ticks until the partial packet times out
    task automatic flush_partial();
        while (pkt_count != 0)
            offer_request(REQ_TICK, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_code();
        if ($urandom_range(99) < 25)
        begin
            case ($urandom_range(4, 0))
                0: return CODE_0A;
                1: return CODE_E0;
                2: return CODE_E4;
                3: return CODE_E6;
                default: return CODE_E8;
            endcase
        end
        return 8'($urandom);
    endfunction

    function automatic logic [WAIT_W-1:0] pick_limit();
        case ($urandom_range(3, 0))
            0: return WAIT_W'($urandom_range(4, 0));
            1, 2: return WAIT_W'($urandom_range(70, 16));
            default: return WAIT_W'($urandom_range(120, 70));
        endcase
    endfunction

    task automatic random_traffic_step();
        int roll;
        int len;
        roll = $urandom_range(99);
        if (roll < 65)
        begin
            // well-formed frame, usually from a clean state
            if (pkt_count != 0 && limit_reg <= 120 && $urandom_range(3) != 0)
                flush_partial();
            len = ($urandom_range(9) == 0) ? 2 * $urandom_range(32, 9)
                                           : 2 * $urandom_range(8, 3);
            send_frame(len, 8'($urandom), pick_code(), $urandom_range(6) == 0, len);
        end
        else if (roll < 80)
            repeat ($urandom_range(6, 1)) offer_request(REQ_TICK, 8'($urandom));
        else if (roll < 90)
            repeat ($urandom_range(5, 1)) offer_request(REQ_BYTE, 8'($urandom));
        else
        begin
            // truncated frame
            len = 2 * $urandom_range(8, 3);
            send_frame(len, 8'($urandom), pick_code(), 1'b0, $urandom_range(len - 1, 1));
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset value of the limit: a partial packet survives a run of idle ticks
    task automatic test_default_limit();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        offer_request(REQ_BYTE, 8'h55);
        repeat (40) offer_request(REQ_TICK, 8'($urandom));
    endtask

    task automatic test_directed();
        write_limit(WAIT_W'(8));
        offer_request(REQ_TICK, 8'hFF);
        send_frame(6, 8'h00, 8'hFF, 1'b0, 6);
        send_frame(8, 8'hFF, 8'h00, 1'b0, 8);
        // rejected at both six and eight bytes
        send_frame(8, 8'h3C, CODE_E4, 1'b0, 8);
        flush_partial();
        send_frame(6, 8'hA5, 8'h01, 1'b1, 6);
        flush_partial();
    endtask

    task automatic test_limit_extremes();
        write_limit('0);
        offer_request(REQ_BYTE, 8'h12);
        offer_request(REQ_BYTE, 8'h34);
        offer_request(REQ_TICK, 8'h00);
        write_limit(WAIT_MAX);
        repeat (4) offer_request(REQ_BYTE, 8'($urandom));
        repeat (2) offer_request(REQ_TICK, 8'($urandom));
        write_limit('0);
        offer_request(REQ_TICK, 8'h00);
    endtask

    // fill the buffer, then push bytes past capacity
    task automatic test_overflow();
        write_limit(WAIT_W'($urandom_range(20'hFFFFE, 300)));
        repeat (BUFFER_BYTES_DEF + 3) offer_request(REQ_BYTE, 8'($urandom));
        offer_request(REQ_TICK, 8'($urandom));
        write_limit('0);
        offer_request(REQ_TICK, 8'($urandom));
    endtask

    // long result stall while frames keep coming, then a full drain
    task automatic test_backpressure();
        int len;
        write_limit(WAIT_W'(64));
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_req       = 150;
        repeat (4)
        begin
            len = 2 * $urandom_range(5, 3);
            send_frame(len, 8'($urandom), 8'($urandom), 1'b0, len);
        end
        drain();
        repeat (3) send_frame(6, 8'($urandom), 8'($urandom), 1'b0, 6);
    endtask

    task automatic test_random_phase(input int gap_pct, input int stall_pct, input int count);
        int target;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (3)
        begin
            write_limit(pick_limit());
            target = items_sent + count / 3;
            while (items_sent < target)
                random_traffic_step();
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_default_limit();
        test_directed();
        test_limit_extremes();
        test_overflow();
        test_backpressure();
        test_random_phase(30, 48, 240);
        test_random_phase(48, 30, 240);
        test_random_phase(0, 0, 240);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** serial_packet_receive_validator_core: PASSED **");
        else
            $display("** serial_packet_receive_validator_core: FAILED **");
        $finish;
    end

endmodule
